/* hw/rtl/vvts_pkg.sv */
package vvts_pkg;

  // Frame phases, one-hot coded.
  typedef enum logic [5:0] {
    PH_START = 6'b000001,
    PH_SYNC  = 6'b000010,
    PH_BACK  = 6'b000100,
    PH_DISP  = 6'b001000,
    PH_BLANK = 6'b010000,
    PH_FRONT = 6'b100000
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_TOTAL_LINES  = 3'd0;
  localparam logic [2:0] REG_SYNC_LINES   = 3'd1;
  localparam logic [2:0] REG_FRONT_PORCH  = 3'd2;
  localparam logic [2:0] REG_BACK_PORCH   = 3'd3;
  localparam logic [2:0] REG_TEXT_ROWS    = 3'd4;
  localparam logic [2:0] REG_LINE_DOUBLER = 3'd5;

  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [7:0] BCD_LAST      = 8'h59;
  localparam logic [3:0] BCD_DIGIT_MAX = 4'h9;
  localparam logic [7:0] BCD_CARRY_ADD = 8'h07;
  localparam logic [7:0] LED_FRAMES    = 8'h04;

  // Next value of a two-digit BCD counter that wraps from 59 to 00.
  function automatic logic [7:0] bcd_next(input logic [7:0] v);
    logic [7:0] r;
    if (v[3:0] == BCD_DIGIT_MAX) begin
      r = (v == BCD_LAST) ? 8'h00 : v + BCD_CARRY_ADD;
    end else begin
      r = v + 8'h01;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/video_vertical_timing_sequencer.sv */
// The result of an accepted line tick is in the output register on the next clock edge.
// Throughput: one item per clock cycle, held back only while the output register is
// full and the receiver stalls.
// Reset (synchronous, active high) clears the output register, returns the sequencer to
// frame start with vsync high and the LED off, and loads the default video geometry.
module video_vertical_timing_sequencer
  import vvts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port.
  input  logic                  cfg_write_enable,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Line tick input channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            switch_value,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  vsync_level,
  output logic                  display_active,
  output logic [6:0]            text_row,
  output logic [2:0]            font_row,
  output logic [6:0]            frame_bcd,
  output logic                  led_on,
  output logic                  mode_changed
);

  // The programmed registers. They take effect only when the geometry is latched, which
  // happens on the first tick after reset and on every restart caused by a mode change.
  logic [10:0] cfg_total;
  logic [7:0]  cfg_sync;
  logic [7:0]  cfg_front;
  logic [7:0]  cfg_back;
  logic [5:0]  cfg_rows;
  logic        cfg_dbl;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_total <= 11'd525;
      cfg_sync  <= 8'd2;
      cfg_front <= 8'd10;
      cfg_back  <= 8'd33;
      cfg_rows  <= 6'd30;
      cfg_dbl   <= 1'b1;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_TOTAL_LINES:  cfg_total <= cfg_data;
        REG_SYNC_LINES:   cfg_sync  <= cfg_data[7:0];
        REG_FRONT_PORCH:  cfg_front <= cfg_data[7:0];
        REG_BACK_PORCH:   cfg_back  <= cfg_data[7:0];
        REG_TEXT_ROWS:    cfg_rows  <= cfg_data[5:0];
        REG_LINE_DOUBLER: cfg_dbl   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Geometry derived from the programmed registers. The visible line count is the total
  // less sync and both porches, floored at zero. The display count is the smaller of the
  // visible lines and the text height in lines; the rest of the visible lines are blank.
  logic [9:0]  porch_sum;
  logic [10:0] vis_lines;
  logic [9:0]  text_lines;
  logic [9:0]  new_disp;
  logic [10:0] new_blank;

  always_comb begin
    porch_sum  = {2'b00, cfg_sync} + {2'b00, cfg_front} + {2'b00, cfg_back};
    vis_lines  = ({1'b0, porch_sum} >= cfg_total) ? 11'd0 : cfg_total - {1'b0, porch_sum};
    text_lines = cfg_dbl ? {cfg_rows, 4'b0000} : {1'b0, cfg_rows, 3'b000};
    new_disp   = (vis_lines < {1'b0, text_lines}) ? vis_lines[9:0] : text_lines;
    new_blank  = vis_lines - {1'b0, new_disp};
  end

  // Latched working geometry.
  logic [7:0]  geo_sync;
  logic [7:0]  geo_front;
  logic [7:0]  geo_back;
  logic        geo_dbl;
  logic [9:0]  geo_disp;
  logic [10:0] geo_blank;

  // Sequencer state.
  phase_t      phase;
  logic [10:0] lines_left;
  logic [7:0]  frame_count;
  logic [3:0]  last_switch;
  logic        led_state;
  logic        vsync_state;
  logic        primed;

  phase_t      phase_next;
  logic [10:0] lines_left_next;
  logic [7:0]  frame_count_next;
  logic [3:0]  last_switch_next;
  logic        led_state_next;
  logic        vsync_state_next;

  // Geometry seen by this tick: the first tick after reset latches and uses it at once.
  logic [7:0]  use_sync;
  logic [7:0]  use_front;
  logic [7:0]  use_back;
  logic        use_dbl;
  logic [9:0]  use_disp;
  logic [10:0] use_blank;
  logic [3:0]  use_last;

  logic        latch;
  logic        last_line;
  logic [10:0] disp_line;
  logic [9:0]  pix_line;
  logic        act;
  logic [6:0]  trow;
  logic [2:0]  frow;
  logic        changed;

  logic        accept;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  always_comb begin
    use_sync  = primed ? geo_sync  : cfg_sync;
    use_front = primed ? geo_front : cfg_front;
    use_back  = primed ? geo_back  : cfg_back;
    use_dbl   = primed ? geo_dbl   : cfg_dbl;
    use_disp  = primed ? geo_disp  : new_disp;
    use_blank = primed ? geo_blank : new_blank;
    use_last  = primed ? last_switch : switch_value;

    latch            = !primed;
    phase_next       = phase;
    lines_left_next  = lines_left - 11'd1;
    frame_count_next = frame_count;
    last_switch_next = use_last;
    led_state_next   = led_state;
    vsync_state_next = vsync_state;
    act              = 1'b0;
    trow             = 7'd0;
    frow             = 3'd0;
    changed          = 1'b0;

    // A phase ends on a tick where at most one line is left, so counts of zero or one
    // both give a single line.
    last_line = (lines_left <= 11'd1);
    disp_line = {1'b0, use_disp} - lines_left;
    pix_line  = use_dbl ? disp_line[10:1] : disp_line[9:0];

    unique case (phase)
      PH_SYNC: begin
        if (last_line) begin
          vsync_state_next = 1'b0;
          phase_next       = PH_BACK;
          lines_left_next  = {3'b000, use_back};
        end
      end
      PH_BACK: begin
        if (last_line) begin
          phase_next      = PH_DISP;
          lines_left_next = {1'b0, use_disp};
        end
      end
      PH_DISP: begin
        act  = 1'b1;
        trow = pix_line[9:3];
        frow = pix_line[2:0];
        if (last_line) begin
          if (use_blank != 11'd0) begin
            phase_next      = PH_BLANK;
            lines_left_next = use_blank;
          end else begin
            phase_next      = PH_FRONT;
            lines_left_next = {3'b000, use_front};
          end
        end
      end
      PH_BLANK: begin
        if (last_line) begin
          phase_next      = PH_FRONT;
          lines_left_next = {3'b000, use_front};
        end
      end
      PH_FRONT: begin
        if (last_line) begin
          frame_count_next = bcd_next(frame_count);
          phase_next       = PH_START;
          lines_left_next  = lines_left;
          // A switch change at frame end restarts with freshly latched geometry.
          if (switch_value != use_last) begin
            last_switch_next = switch_value;
            changed          = 1'b1;
            latch            = 1'b1;
            frame_count_next = 8'h00;
            lines_left_next  = 11'd0;
          end
        end
      end
      default: begin
        // Frame start; any code that is not a phase also lands here.
        vsync_state_next = 1'b1;
        led_state_next   = (frame_count < LED_FRAMES);
        lines_left_next  = {3'b000, use_sync};
        phase_next       = PH_SYNC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_START;
      lines_left  <= 11'd0;
      frame_count <= 8'h00;
      last_switch <= 4'd0;
      led_state   <= 1'b0;
      vsync_state <= 1'b1;
      primed      <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      lines_left  <= lines_left_next;
      frame_count <= frame_count_next;
      last_switch <= last_switch_next;
      led_state   <= led_state_next;
      vsync_state <= vsync_state_next;
      primed      <= 1'b1;
    end
  end

  // Geometry is latched from the programmed registers; it needs no reset because the
  // first accepted tick always loads it.
  always_ff @(posedge clk) begin
    if (accept && latch) begin
      geo_sync  <= cfg_sync;
      geo_front <= cfg_front;
      geo_back  <= cfg_back;
      geo_dbl   <= cfg_dbl;
      geo_disp  <= new_disp;
      geo_blank <= new_blank;
    end
  end

  // Output register. A new item is taken whenever the register is empty or its item is
  // being taken in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vsync_level    <= vsync_state_next;
      display_active <= act;
      text_row       <= trow;
      font_row       <= frow;
      frame_bcd      <= frame_count_next[6:0];
      led_on         <= led_state_next;
      mode_changed   <= changed;
    end
  end

  // A restart always clears the frame counter.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && mode_changed |-> frame_bcd == 7'd0)
    else $error("restart item without cleared frame counter");

  // Display lines lie between the end of sync and the next frame start.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && display_active |-> !vsync_level)
    else $error("display line during vertical sync");

  // Every accepted tick yields a result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // The frame counter stays a valid BCD value.
  assert property (@(posedge clk) disable iff (rst)
    frame_count[3:0] <= BCD_DIGIT_MAX && frame_count <= BCD_LAST)
    else $error("frame counter left BCD range");

endmodule

/* bench/vvts_line_checker.sv */
module vvts_line_checker
  import vvts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_enable,
  input  logic [2:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [3:0]            switch_value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  vsync_level,
  input  logic                  display_active,
  input  logic [6:0]            text_row,
  input  logic [2:0]            font_row,
  input  logic [6:0]            frame_bcd,
  input  logic                  led_on,
  input  logic                  mode_changed,
  output int                    mismatches,
  output int                    awaiting
);

  typedef struct packed {
    logic       vsync;
    logic       active;
    logic [6:0] text_row;
    logic [2:0] font_row;
    logic [6:0] frame;
    logic       led;
    logic       changed;
  } line_result_t;

  typedef struct packed {
    logic [10:0] total;
    logic [7:0]  sync;
    logic [7:0]  front;
    logic [7:0]  back;
    logic [5:0]  rows;
    logic        doubler;
  } geometry_t;

  geometry_t    written_geo;
  geometry_t    active_geo;
  phase_t       phase;
  logic [10:0]  lines_left;
  logic [10:0]  disp_count;
  logic [10:0]  blank_count;
  logic [7:0]   frame_count;
  logic [3:0]   last_switch;
  logic         led_state;
  logic         vsync_state;
  logic         started;
  line_result_t expected_lines[$];
  int           fail_total = 0;

  assign mismatches = fail_total;

  // The register copies take effect only here, at the first tick and at a restart.
  task automatic latch_geometry();
    int visible;
    int text_lines;
    active_geo = written_geo;
    visible = int'(active_geo.total) - int'(active_geo.sync) - int'(active_geo.front)
              - int'(active_geo.back);
    if (visible < 0) visible = 0;
    text_lines = int'(active_geo.rows) << (active_geo.doubler ? 4 : 3);
    disp_count = (visible < text_lines) ? 11'(visible) : 11'(text_lines);
    blank_count = 11'(visible) - disp_count;
  endtask

  task automatic predict_line(input logic [3:0] sw, output line_result_t r);
    logic [10:0] line;
    r = '0;
    if (!started) begin
      last_switch = sw;
      latch_geometry();
      started = 1'b1;
    end
    case (phase)
      PH_SYNC: begin
        if (lines_left <= 11'd1) begin
          vsync_state = 1'b0;
          phase = PH_BACK;
          lines_left = 11'(active_geo.back);
        end else begin
          lines_left = lines_left - 11'd1;
        end
      end
      PH_BACK: begin
        if (lines_left <= 11'd1) begin
          phase = PH_DISP;
          lines_left = disp_count;
        end else begin
          lines_left = lines_left - 11'd1;
        end
      end
      PH_DISP: begin
        line = disp_count - lines_left;
        if (active_geo.doubler) line = line >> 1;
        r.text_row = line[9:3];
        r.font_row = line[2:0];
        r.active = 1'b1;
        if (lines_left <= 11'd1) begin
          if (blank_count != 11'd0) begin
            phase = PH_BLANK;
            lines_left = blank_count;
          end else begin
            phase = PH_FRONT;
            lines_left = 11'(active_geo.front);
          end
        end else begin
          lines_left = lines_left - 11'd1;
        end
      end
      PH_BLANK: begin
        if (lines_left <= 11'd1) begin
          phase = PH_FRONT;
          lines_left = 11'(active_geo.front);
        end else begin
          lines_left = lines_left - 11'd1;
        end
      end
      PH_FRONT: begin
        if (lines_left <= 11'd1) begin
          if (frame_count[3:0] == BCD_DIGIT_MAX) begin
            frame_count = (frame_count == BCD_LAST) ? 8'h00 : frame_count + BCD_CARRY_ADD;
          end else begin
            frame_count = frame_count + 8'h01;
          end
          phase = PH_START;
          if (sw != last_switch) begin
            last_switch = sw;
            r.changed = 1'b1;
            latch_geometry();
            frame_count = 8'h00;
            lines_left = 11'd0;
          end
        end else begin
          lines_left = lines_left - 11'd1;
        end
      end
      default: begin
        vsync_state = 1'b1;
        led_state = (frame_count < LED_FRAMES);
        lines_left = 11'(active_geo.sync);
        phase = PH_SYNC;
      end
    endcase
    r.vsync = vsync_state;
    r.frame = frame_count[6:0];
    r.led = led_state;
  endtask

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    line_result_t want;
    if (rst) begin
      written_geo = '{total: 11'd525, sync: 8'd2, front: 8'd10, back: 8'd33,
                      rows: 6'd30, doubler: 1'b1};
      active_geo = written_geo;
      phase = PH_START;
      lines_left = 11'd0;
      disp_count = 11'd0;
      blank_count = 11'd0;
      frame_count = 8'h00;
      last_switch = 4'd0;
      led_state = 1'b0;
      vsync_state = 1'b1;
      started = 1'b0;
      expected_lines.delete();
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          REG_TOTAL_LINES:  written_geo.total = cfg_data[10:0];
          REG_SYNC_LINES:   written_geo.sync = cfg_data[7:0];
          REG_FRONT_PORCH:  written_geo.front = cfg_data[7:0];
          REG_BACK_PORCH:   written_geo.back = cfg_data[7:0];
          REG_TEXT_ROWS:    written_geo.rows = cfg_data[5:0];
          REG_LINE_DOUBLER: written_geo.doubler = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_lines.size() == 0) begin
          $display("%0t: result with no line tick pending, expected none, got frame %02h",
                   $time, frame_bcd);
          fail_total++;
        end else begin
          want = expected_lines.pop_front();
          compare_field("vsync_level", int'(want.vsync), int'(vsync_level));
          compare_field("display_active", int'(want.active), int'(display_active));
          compare_field("text_row", int'(want.text_row), int'(text_row));
          compare_field("font_row", int'(want.font_row), int'(font_row));
          compare_field("frame_bcd", int'(want.frame), int'(frame_bcd));
          compare_field("led_on", int'(want.led), int'(led_on));
          compare_field("mode_changed", int'(want.changed), int'(mode_changed));
        end
      end
      if (in_valid && !in_stall) begin
        predict_line(switch_value, want);
        expected_lines.push_back(want);
      end
    end
    awaiting <= expected_lines.size();
  end

endmodule

/* bench/video_vertical_timing_sequencer_tb.sv */
module video_vertical_timing_sequencer_tb;
  import vvts_pkg::*;

  // Random part stops once this many line ticks have gone in; the run into a full-size
  // frame at the very end comes on top of it.
  localparam int LINE_TARGET = 700;
  // Cycles without any handshake or register write before the run is declared hung.
  localparam int HANG_LIMIT = 3000;
  // Switch readings of the two opening frames, first tick in the top nibble.
  localparam logic [39:0] OPENING_SWITCHES = 40'hffff000000;

  typedef enum {SW_HOLD, SW_DRIFT, SW_NOISE} switch_habit_t;
  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_habit_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write_enable = 1'b0;
  logic [2:0]            cfg_index = REG_TOTAL_LINES;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [3:0]            switch_value = 4'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  vsync_level;
  logic                  display_active;
  logic [6:0]            text_row;
  logic [2:0]            font_row;
  logic [6:0]            frame_bcd;
  logic                  led_on;
  logic                  mode_changed;

  int           mismatches;
  int           awaiting;
  int           lines_sent = 0;
  int           burst_left = 0;
  int           quiet_cycles = 0;
  int           stall_span = 0;
  stall_habit_t stall_habit = STALL_NONE;
  logic [3:0]   held_switch = 4'd0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  video_vertical_timing_sequencer uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .switch_value     (switch_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .vsync_level      (vsync_level),
    .display_active   (display_active),
    .text_row         (text_row),
    .font_row         (font_row),
    .frame_bcd        (frame_bcd),
    .led_on           (led_on),
    .mode_changed     (mode_changed)
  );

  vvts_line_checker line_check (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .switch_value     (switch_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .vsync_level      (vsync_level),
    .display_active   (display_active),
    .text_row         (text_row),
    .font_row         (font_row),
    .frame_bcd        (frame_bcd),
    .led_on           (led_on),
    .mode_changed     (mode_changed),
    .mismatches       (mismatches),
    .awaiting         (awaiting)
  );

  // The result side keeps a stall habit for a random span of cycles: no stalls at all,
  // an occasional stall, or stalling most of the time so that the output register backs
  // up and the block has to hold off new items.
  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_habit <= stall_habit_t'($urandom_range(0, 2));
      stall_span <= $urandom_range(16, 240);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_habit)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      default:     out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Hang detection: any accepted item or register write restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write_enable) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one line tick and returns once it is accepted. The sender works in bursts;
  // between most bursts valid drops low. Now and then a long burst runs with no
  // gap at all. Valid stays high from one item to the next inside a burst.
  task automatic send_line(input logic [3:0] sw);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = $urandom_range(40, 200);
      end else begin
        gap = $urandom_range(1, 10);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    switch_value <= sw;
    held_switch = sw;
    do @(posedge clk); while (in_stall);
    burst_left--;
    lines_sent++;
  endtask

  // Stops the sender and waits until every predicted result has come out, so that the
  // block is idle before the registers are touched or the run ends.
  task automatic settle_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
  endtask

  // Writes all six registers on back-to-back cycles. Half the time the unused upper bits
  // of the narrower registers carry random junk, which the block has to drop.
  task automatic program_geometry(input logic [10:0] total, input logic [7:0] sync,
                                  input logic [7:0] front, input logic [7:0] back,
                                  input logic [5:0] rows, input logic doubler);
    logic [CFG_DATA_W-1:0] value [0:5];
    logic [CFG_DATA_W-1:0] junk;
    logic [2:0]            idx;
    junk = ($urandom_range(0, 1) == 0) ? '0 : CFG_DATA_W'($urandom);
    value[REG_TOTAL_LINES] = total;
    value[REG_SYNC_LINES] = {junk[2:0], sync};
    value[REG_FRONT_PORCH] = {junk[5:3], front};
    value[REG_BACK_PORCH] = {junk[8:6], back};
    value[REG_TEXT_ROWS] = {junk[4:0], rows};
    value[REG_LINE_DOUBLER] = {junk[9:0], doubler};
    cfg_write_enable <= 1'b1;
    idx = REG_TOTAL_LINES;
    repeat (6) begin
      cfg_index <= idx;
      cfg_data <= value[idx];
      @(posedge clk);
      idx = idx + 3'd1;
    end
    cfg_write_enable <= 1'b0;
  endtask

  // A phase opens with a switch reading that differs from the last one, so the frame
  // that is running ends in a restart and the new geometry is latched. After that the
  // switch is held, drifts now and then, or is pure noise.
  task automatic run_phase(input int count, input switch_habit_t habit);
    logic [3:0] sw;
    sw = held_switch ^ 4'($urandom_range(1, 15));
    repeat (count) begin
      send_line(sw);
      case (habit)
        SW_DRIFT: if ($urandom_range(0, 39) == 0) sw = 4'($urandom);
        SW_NOISE: sw = 4'($urandom);
        default: ;
      endcase
    end
  endtask

  initial begin
    int         kind;
    int         total;
    logic [7:0] sync;
    logic [7:0] front;
    logic [7:0] back;
    logic [5:0] rows;
    logic       doubler;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Porches that swallow the whole frame: no visible lines, yet one display line per
    // frame, five ticks in all. The first tick takes 15 as its start-up reading, the
    // switch then drops to 0 at the first frame end for a restart, and the second frame
    // ends with no change.
    program_geometry(11'd3, 8'd1, 8'd1, 8'd1, 6'd4, 1'b0);
    for (int i = 0; i < 10; i++) send_line(OPENING_SWITCHES[39 - 4 * i -: 4]);

    // All counts zero, doubler on: every phase ends on its first tick and the display
    // still shows one line. The switch change latches this at the next frame end.
    settle_results();
    program_geometry(11'd0, 8'd0, 8'd0, 8'd0, 6'd0, 1'b1);
    repeat (10) send_line(4'h6);

    // Shortest frames with the switch held long enough for the frame counter to run
    // past 59 and wrap, with the LED going through its lit frames again.
    settle_results();
    program_geometry(11'd1, 8'd1, 8'd1, 8'd1, 6'd63, 1'b0);
    run_phase(320, SW_HOLD);

    // Random geometries, kept small so that many frames and restarts go by: tiny frames
    // with overfull porches, small frames where the display ends before the visible
    // lines do and blank lines follow, and once in a while a medium frame.
    while (lines_sent < LINE_TARGET) begin
      settle_results();
      kind = $urandom_range(0, 5);
      doubler = 1'($urandom_range(0, 1));
      if (kind < 2) begin
        sync = 8'($urandom_range(0, 3));
        back = 8'($urandom_range(0, 3));
        front = 8'($urandom_range(0, 3));
        rows = 6'($urandom_range(0, 63));
        total = int'($urandom_range(0, 8));
      end else if (kind < 5) begin
        sync = 8'($urandom_range(0, 4));
        back = 8'($urandom_range(0, 4));
        front = 8'($urandom_range(0, 4));
        rows = 6'($urandom_range(0, 6));
        total = int'(sync) + int'(back) + int'(front)
                + int'($urandom_range(0, int'(rows) * (doubler ? 16 : 8) + 24));
      end else begin
        sync = 8'($urandom_range(1, 40));
        back = 8'($urandom_range(1, 40));
        front = 8'($urandom_range(1, 40));
        rows = 6'($urandom_range(4, 20));
        total = int'($urandom_range(0, 300));
      end
      program_geometry(11'(total), sync, front, back, rows, doubler);
      run_phase($urandom_range(40, 160), switch_habit_t'($urandom_range(0, 2)));
    end

    // Every register at its top value: the frame in progress runs out, the restart
    // latches the full-size geometry, and its long sync pulse and back porch follow.
    settle_results();
    program_geometry(11'd2047, 8'd255, 8'd255, 8'd255, 6'd63, 1'b1);
    run_phase(600, SW_HOLD);

    settle_results();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && awaiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/vvts_pkg.sv
hw/rtl/video_vertical_timing_sequencer.sv
bench/vvts_line_checker.sv
bench/video_vertical_timing_sequencer_tb.sv
